// ----- design/tpmc_pkg.sv -----
package tpmc_pkg;

    localparam int MOTOR_COUNT      = 8;
    localparam int TOP_PACKET_BYTES = 11;

    localparam int PAY_LEN   = TOP_PACKET_BYTES - 3;
    localparam int POS_W     = $clog2(TOP_PACKET_BYTES);
    localparam int MOTOR_W   = 4;
    localparam int STORE_DEPTH = 16;
    localparam int STORE_AW  = 4;

    localparam logic [7:0] START_BYTE = 8'h12;
    localparam logic [7:0] END_BYTE   = 8'h13;
    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam logic [7:0] MAG_ALIAS  = 8'd18;
    localparam logic [7:0] MAG_SUBST  = 8'd17;

    localparam logic [2:0] FRAME_LAST_IDX = 3'd6;

    localparam logic [1:0] STATUS_FRAME   = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_END_ERR = 2'd2;
    localparam logic [1:0] STATUS_ABORT   = 2'd3;

endpackage

// ----- design/tpmc_crc.sv -----
module tpmc_crc (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_crc,
    input  logic [7:0] i_data,
    output logic       o_done,
    output logic [7:0] o_crc
);

    logic       r_busy;
    logic       r_done;
    logic [2:0] r_cnt;
    logic [7:0] r_crc;
    logic [7:0] r_data;
    logic       w_mix;

    assign w_mix = r_crc[0] ^ r_data[0];

    // one bit of the reflected CRC per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_crc  <= i_crc;
            r_data <= i_data;
        end else if (r_busy) begin
            r_crc  <= {1'b0, r_crc[7:1]} ^ (w_mix ? tpmc_pkg::CRC_POLY : 8'h00);
            r_data <= {1'b0, r_data[7:1]};
        end
    end

    assign o_done = r_done;
    assign o_crc  = r_crc;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("crc done without a preceding step");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 3'd7 && !i_start) |=> r_done)
        else $error("crc unit missed its final step");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("crc done while still stepping");

endmodule

// ----- design/top_packet_to_motor_commands.sv -----
// Flow: a payload byte holds the input through accept, 8 CRC bit steps and handoff;
// start and checksum bytes are handled in S_IDLE alone, a byte that ends in a status goes to S_STAT.
// A status result passes through S_STAT and the output register. A good packet emits MOTOR_COUNT*7 result
// items, each frame going through one load, 4 CRC bytes and 7 emits, plus any output stall.
// Input: o_ready is low until the last byte is through; a good end byte holds it until all frames are out.
// Reset (synchronous, active low): idle waiting for start, check enabled, output empty.
module top_packet_to_motor_commands (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_tx_byte,
    output logic [1:0] o_status,
    output logic       o_last
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RXCRC = 6'b000010,
        S_LOAD  = 6'b000100,
        S_FCRC  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_STAT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [tpmc_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [7:0]                   r_rcrc, n_rcrc;
    logic [7:0]                   r_recv, n_recv;
    logic                         r_check_en;
    logic [tpmc_pkg::MOTOR_W-1:0] r_m, n_m;
    logic [1:0]                   r_k, n_k;
    logic [2:0]                   r_j, n_j;
    logic                         r_dir, n_dir;
    logic [7:0]                   r_mag, n_mag;
    logic [7:0]                   r_fcrc, n_fcrc;
    logic [1:0]                   r_stat, n_stat;
    logic [7:0]                   r_store [tpmc_pkg::STORE_DEPTH];

    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic [1:0] r_ostatus;
    logic       r_olast;

    logic       w_accept;
    logic       w_out_free;
    logic       w_store_we;
    logic [tpmc_pkg::STORE_AW-1:0] w_store_addr;
    logic       load_out;
    logic [7:0] out_byte;
    logic [1:0] out_status;
    logic       out_last;
    logic       crc_start;
    logic [7:0] crc_init;
    logic [7:0] crc_data;
    logic       crc_done;
    logic [7:0] crc_out;
    logic [2:0] w_sel;
    logic [7:0] w_frame_byte;
    logic [7:0] w_pay;
    logic [7:0] w_mag_raw;
    logic [tpmc_pkg::POS_W:0] w_pos_m1;

    tpmc_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crc_start),
        .i_crc   (crc_init),
        .i_data  (crc_data),
        .o_done  (crc_done),
        .o_crc   (crc_out)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;

    assign w_pos_m1     = {1'b0, r_pos} - 1'b1;
    assign w_store_addr = w_pos_m1[tpmc_pkg::STORE_AW-1:0];

    assign w_pay     = r_store[r_m];
    assign w_mag_raw = {w_pay[6:0], 1'b0};

    // frame byte index: CRC pass selects bytes 2..4 (byte 1 is fed in S_LOAD), emit walks 0..6
    assign w_sel = (r_state == S_FCRC) ? ({1'b0, r_k} + 3'd2) : r_j;

    always_comb begin
        unique case (w_sel)
            3'd0:    w_frame_byte = tpmc_pkg::START_BYTE;
            3'd1:    w_frame_byte = 8'(r_m) + 8'd1;
            3'd2:    w_frame_byte = 8'd1;
            3'd3:    w_frame_byte = {7'd0, r_dir};
            3'd4:    w_frame_byte = r_mag;
            3'd5:    w_frame_byte = r_fcrc;
            3'd6:    w_frame_byte = tpmc_pkg::END_BYTE;
            default: w_frame_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_rcrc     = r_rcrc;
        n_recv     = r_recv;
        n_m        = r_m;
        n_k        = r_k;
        n_j        = r_j;
        n_dir      = r_dir;
        n_mag      = r_mag;
        n_fcrc     = r_fcrc;
        n_stat     = r_stat;
        w_store_we = 1'b0;
        crc_start  = 1'b0;
        crc_init   = r_rcrc;
        crc_data   = i_rx_byte;
        load_out   = 1'b0;
        out_byte   = 8'd0;
        out_status = tpmc_pkg::STATUS_FRAME;
        out_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority if (r_pos == '0) begin
                        if (i_rx_byte == tpmc_pkg::START_BYTE) begin
                            n_pos  = tpmc_pkg::POS_W'(1);
                            n_rcrc = 8'd0;
                        end
                    end else if (i_rx_byte == tpmc_pkg::START_BYTE) begin
                        n_pos   = '0;
                        n_stat  = tpmc_pkg::STATUS_ABORT;
                        n_state = S_STAT;
                    end else if (r_pos <= tpmc_pkg::POS_W'(tpmc_pkg::PAY_LEN)) begin
                        w_store_we = 1'b1;
                        crc_start  = 1'b1;
                        n_pos      = r_pos + 1'b1;
                        n_state    = S_RXCRC;
                    end else if (r_pos == tpmc_pkg::POS_W'(tpmc_pkg::PAY_LEN + 1)) begin
                        n_recv = i_rx_byte;
                        n_pos  = r_pos + 1'b1;
                    end else begin
                        n_pos = '0;
                        priority if (r_check_en && r_rcrc != r_recv) begin
                            n_stat  = tpmc_pkg::STATUS_CRC_ERR;
                            n_state = S_STAT;
                        end else if (r_check_en && i_rx_byte != tpmc_pkg::END_BYTE) begin
                            n_stat  = tpmc_pkg::STATUS_END_ERR;
                            n_state = S_STAT;
                        end else begin
                            n_m     = '0;
                            n_state = S_LOAD;
                        end
                    end
                end
            end
            S_RXCRC: begin
                if (crc_done) begin
                    n_rcrc  = crc_out;
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                n_dir = !w_pay[7];
                n_mag = (w_mag_raw == tpmc_pkg::MAG_ALIAS) ? tpmc_pkg::MAG_SUBST : w_mag_raw;
                // first CRC byte is the address, independent of dir and mag
                crc_start = 1'b1;
                crc_init  = 8'd0;
                crc_data  = 8'(r_m) + 8'd1;
                n_k       = 2'd0;
                n_state   = S_FCRC;
            end
            S_FCRC: begin
                if (crc_done) begin
                    if (r_k == 2'd3) begin
                        n_fcrc  = crc_out;
                        n_j     = 3'd0;
                        n_state = S_EMIT;
                    end else begin
                        crc_start = 1'b1;
                        crc_init  = crc_out;
                        crc_data  = w_frame_byte;
                        n_k       = r_k + 2'd1;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    load_out = 1'b1;
                    out_byte = w_frame_byte;
                    out_last = (r_m == tpmc_pkg::MOTOR_W'(tpmc_pkg::MOTOR_COUNT - 1))
                               && (r_j == tpmc_pkg::FRAME_LAST_IDX);
                    if (r_j == tpmc_pkg::FRAME_LAST_IDX) begin
                        if (r_m == tpmc_pkg::MOTOR_W'(tpmc_pkg::MOTOR_COUNT - 1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_m     = r_m + 1'b1;
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_j = r_j + 3'd1;
                    end
                end
            end
            S_STAT: begin
                if (w_out_free) begin
                    load_out   = 1'b1;
                    out_status = r_stat;
                    out_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_rcrc     <= 8'd0;
            r_recv     <= 8'd0;
            r_check_en <= 1'b1;
            r_ovalid   <= 1'b0;
            r_m        <= '0;
            r_k        <= '0;
            r_j        <= '0;
            r_stat     <= tpmc_pkg::STATUS_FRAME;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_rcrc  <= n_rcrc;
            r_recv  <= n_recv;
            r_m     <= n_m;
            r_k     <= n_k;
            r_j     <= n_j;
            r_stat  <= n_stat;
            if (i_cfg_we) begin
                r_check_en <= i_cfg_wdata;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir  <= n_dir;
        r_mag  <= n_mag;
        r_fcrc <= n_fcrc;
        if (load_out) begin
            r_obyte   <= out_byte;
            r_ostatus <= out_status;
            r_olast   <= out_last;
        end
        if (w_store_we) begin
            r_store[w_store_addr] <= i_rx_byte;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_tx_byte = r_obyte;
    assign o_status  = r_ostatus;
    assign o_last    = r_olast;

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != tpmc_pkg::STATUS_FRAME) |-> (o_last && o_tx_byte == 8'd0))
        else $error("status item must be a lone zero-byte last item");

    a_last_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && o_status == tpmc_pkg::STATUS_FRAME)
            |-> (o_tx_byte == tpmc_pkg::END_BYTE))
        else $error("last frame item is not the end byte");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= tpmc_pkg::POS_W'(tpmc_pkg::TOP_PACKET_BYTES - 1))
        else $error("packet position out of range");

    a_crc_done_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crc_done |-> (r_state == S_RXCRC || r_state == S_FCRC))
        else $error("crc result arrived with no consumer");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> ($stable(r_obyte) && $stable(r_ostatus) && r_ovalid))
        else $error("pending result overwritten");

endmodule

// ----- dv/top_packet_to_motor_commands_tb.sv -----
`timescale 1ns / 1ps

module top_packet_to_motor_commands_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int DRAIN_CYCLES   = 50;
    localparam int PHASE_ITEMS    = 60;

    typedef struct packed {
        logic [7:0] tx;
        logic [1:0] status;
        logic       last;
    } t_motor_item;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_STATUS
    } t_row_kind;

    typedef struct packed {
        logic [7:0] data;
        t_row_kind  kind;
        logic [1:0] st;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_wdata;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_tx_byte;
    logic [1:0] o_status;
    logic       o_last;

    // Predictor state
    int          pkt_pos;
    logic [7:0]  pay_bytes [tpmc_pkg::PAY_LEN];
    logic [7:0]  pkt_crc;
    logic [7:0]  rx_crc;
    logic        chk_en;

    t_motor_item exp_frames [$];
    t_motor_item new_frames [$];
    t_motor_item mon_exp;
    t_stim_row   dir_rows [$];

    int          errors = 0;
    int          rx_count = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    logic [7:0]  rdy_cnt = '0;
    logic [1:0]  rdy_mode = '0;

    top_packet_to_motor_commands u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rx_byte  (i_rx_byte),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_tx_byte  (o_tx_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ tpmc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    // Advance the packet state by one byte; return 1 when the byte is ignored.
    function automatic bit predict_motor_frames(input logic [7:0] b);
        logic [7:0] mag;
        logic [7:0] fcrc;
        logic [7:0] fr [7];
        new_frames.delete();
        if (pkt_pos == 0) begin
            if (b == tpmc_pkg::START_BYTE) begin
                pkt_pos = 1;
                pkt_crc = '0;
                return 1'b0;
            end
            return 1'b1;
        end
        if (b == tpmc_pkg::START_BYTE) begin
            pkt_pos = 0;
            new_frames.push_back(t_motor_item'{8'h00, tpmc_pkg::STATUS_ABORT, 1'b1});
            return 1'b0;
        end
        if (pkt_pos <= tpmc_pkg::PAY_LEN) begin
            pay_bytes[pkt_pos - 1] = b;
            pkt_crc = crc8_step(pkt_crc, b);
            pkt_pos++;
            return 1'b0;
        end
        if (pkt_pos == tpmc_pkg::PAY_LEN + 1) begin
            rx_crc = b;
            pkt_pos++;
            return 1'b0;
        end
        pkt_pos = 0;
        if (chk_en && pkt_crc != rx_crc) begin
            new_frames.push_back(t_motor_item'{8'h00, tpmc_pkg::STATUS_CRC_ERR, 1'b1});
            return 1'b0;
        end
        if (chk_en && b != tpmc_pkg::END_BYTE) begin
            new_frames.push_back(t_motor_item'{8'h00, tpmc_pkg::STATUS_END_ERR, 1'b1});
            return 1'b0;
        end
        for (int m = 0; m < tpmc_pkg::MOTOR_COUNT; m++) begin
            mag = {pay_bytes[m][6:0], 1'b0};
            if (mag == tpmc_pkg::MAG_ALIAS) begin
                mag = tpmc_pkg::MAG_SUBST;
            end
            fr[0] = tpmc_pkg::START_BYTE;
            fr[1] = 8'(m + 1);
            fr[2] = 8'd1;
            fr[3] = pay_bytes[m][7] ? 8'd0 : 8'd1;
            fr[4] = mag;
            fcrc = '0;
            for (int j = 1; j <= 4; j++) begin
                fcrc = crc8_step(fcrc, fr[j]);
            end
            fr[5] = fcrc;
            fr[6] = tpmc_pkg::END_BYTE;
            for (int j = 0; j < 7; j++) begin
                new_frames.push_back(t_motor_item'{fr[j], tpmc_pkg::STATUS_FRAME,
                                     (m == tpmc_pkg::MOTOR_COUNT - 1) && (j == 6)});
            end
        end
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input t_row_kind kind, input logic [1:0] st);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        if (!predict_motor_frames(b)) begin
            rx_count++;
        end
        case (kind)
            ROW_PREDICT: begin
                foreach (new_frames[k]) exp_frames.push_back(new_frames[k]);
            end
            ROW_STATUS: begin
                exp_frames.push_back(t_motor_item'{8'h00, st, 1'b1});
            end
            default: ;
        endcase
        burst_left--;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
        end
    endtask

    task automatic send_rand(input logic [7:0] b);
        send_byte(b, ROW_PREDICT, tpmc_pkg::STATUS_FRAME);
    endtask

    function automatic logic [7:0] pick_payload();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 5))
                0: return 8'h00;
                1: return 8'hFF;
                2: return 8'h7F;
                3: return 8'h80;
                4: return 8'h09;
                default: return 8'h89;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // abort_at: byte position after the start that is replaced by a start byte; -1 for none
    task automatic send_packet(input bit bad_crc, input bit bad_end, input int abort_at);
        logic [7:0] crc;
        logic [7:0] b;
        crc = '0;
        send_rand(tpmc_pkg::START_BYTE);
        for (int i = 0; i < tpmc_pkg::PAY_LEN; i++) begin
            if (i == abort_at) begin
                send_rand(tpmc_pkg::START_BYTE);
                return;
            end
            b = pick_payload();
            send_rand(b);
            crc = crc8_step(crc, b);
        end
        if (abort_at == tpmc_pkg::PAY_LEN) begin
            send_rand(tpmc_pkg::START_BYTE);
            return;
        end
        send_rand(bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
        if (abort_at == tpmc_pkg::PAY_LEN + 1) begin
            send_rand(tpmc_pkg::START_BYTE);
            return;
        end
        b = 8'($urandom_range(0, 255));
        if (b == tpmc_pkg::END_BYTE) begin
            b = ~b;
        end
        send_rand(bad_end ? b : tpmc_pkg::END_BYTE);
    endtask

    task automatic run_random(input int target);
        int start_cnt;
        int pick;
        start_cnt = rx_count;
        while (rx_count - start_cnt < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_packet(1'b0, 1'b0, -1);
            end else if (pick < 65) begin
                send_packet(1'b1, 1'($urandom_range(0, 1)), -1);
            end else if (pick < 75) begin
                send_packet(1'b0, 1'b1, -1);
            end else if (pick < 85) begin
                send_packet(1'b0, 1'b0, int'($urandom_range(0, tpmc_pkg::PAY_LEN + 1)));
            end else begin
                repeat ($urandom_range(1, 4)) send_rand(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Hold off the sender, let every expected item drain, then write the register.
    task automatic settle_and_write(input logic v);
        if (burst_left != 0) begin
            i_valid    <= 1'b0;
            burst_left = 0;
        end
        while (exp_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        chk_en   = v;
    endtask

    // Receiver stall pattern: switch mode whenever the 8-bit rdy_cnt wraps to zero.
    always @(posedge i_clk) begin
        rdy_cnt <= rdy_cnt + 8'd1;
        if (rdy_cnt == 8'd0) begin
            rdy_mode <= 2'($urandom_range(0, 3));
        end
        case (rdy_mode)
            2'd0:    i_ready <= 1'b1;
            2'd1:    i_ready <= (rdy_cnt[1:0] != 2'd0);
            2'd2:    i_ready <= ($urandom_range(0, 3) != 0);
            default: i_ready <= !rdy_cnt[4];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_frames.size() == 0) begin
                $error("unexpected item: tx_byte=%h status=%0d last=%0d",
                       o_tx_byte, o_status, o_last);
                errors++;
            end else begin
                mon_exp = exp_frames.pop_front();
                if (o_tx_byte !== mon_exp.tx) begin
                    $error("tx_byte: expected %h, actual %h", mon_exp.tx, o_tx_byte);
                    errors++;
                end
                if (o_status !== mon_exp.status) begin
                    $error("status: expected %0d, actual %0d", mon_exp.status, o_status);
                    errors++;
                end
                if (o_last !== mon_exp.last) begin
                    $error("last: expected %0d, actual %0d", mon_exp.last, o_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [7:0] crc;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        pkt_pos     = 0;
        pkt_crc     = '0;
        rx_crc      = '0;
        chk_en      = 1'b1;
        foreach (pay_bytes[k]) pay_bytes[k] = '0;

        // Directed rows: idle byte, abort, one good packet of corner payloads, one bad packet
        dir_rows.push_back(t_stim_row'{8'h55, ROW_NONE, tpmc_pkg::STATUS_FRAME});
        dir_rows.push_back(t_stim_row'{tpmc_pkg::START_BYTE, ROW_NONE, tpmc_pkg::STATUS_FRAME});
        dir_rows.push_back(t_stim_row'{tpmc_pkg::START_BYTE, ROW_STATUS,
                                       tpmc_pkg::STATUS_ABORT});
        dir_rows.push_back(t_stim_row'{tpmc_pkg::START_BYTE, ROW_NONE, tpmc_pkg::STATUS_FRAME});
        crc = '0;
        for (int k = 0; k < tpmc_pkg::PAY_LEN; k++) begin
            case (k)
                0: dir_rows.push_back(t_stim_row'{8'h00, ROW_NONE, tpmc_pkg::STATUS_FRAME});
                1: dir_rows.push_back(t_stim_row'{8'hFF, ROW_NONE, tpmc_pkg::STATUS_FRAME});
                2: dir_rows.push_back(t_stim_row'{8'h7F, ROW_NONE, tpmc_pkg::STATUS_FRAME});
                3: dir_rows.push_back(t_stim_row'{8'h80, ROW_NONE, tpmc_pkg::STATUS_FRAME});
                4: dir_rows.push_back(t_stim_row'{8'h09, ROW_NONE, tpmc_pkg::STATUS_FRAME});
                5: dir_rows.push_back(t_stim_row'{8'h89, ROW_NONE, tpmc_pkg::STATUS_FRAME});
                6: dir_rows.push_back(t_stim_row'{8'h01, ROW_NONE, tpmc_pkg::STATUS_FRAME});
                default: dir_rows.push_back(t_stim_row'{8'hFE, ROW_NONE,
                                                        tpmc_pkg::STATUS_FRAME});
            endcase
            crc = crc8_step(crc, dir_rows[dir_rows.size() - 1].data);
        end
        dir_rows.push_back(t_stim_row'{crc, ROW_NONE, tpmc_pkg::STATUS_FRAME});
        dir_rows.push_back(t_stim_row'{tpmc_pkg::END_BYTE, ROW_PREDICT, tpmc_pkg::STATUS_FRAME});
        // Checksum and end byte both wrong: checksum error wins
        dir_rows.push_back(t_stim_row'{tpmc_pkg::START_BYTE, ROW_NONE, tpmc_pkg::STATUS_FRAME});
        for (int k = 0; k < tpmc_pkg::PAY_LEN; k++) begin
            dir_rows.push_back(t_stim_row'{dir_rows[4 + k].data, ROW_NONE,
                                           tpmc_pkg::STATUS_FRAME});
        end
        dir_rows.push_back(t_stim_row'{crc ^ 8'h5A, ROW_NONE, tpmc_pkg::STATUS_FRAME});
        dir_rows.push_back(t_stim_row'{8'hFF, ROW_STATUS, tpmc_pkg::STATUS_CRC_ERR});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        settle_and_write(1'b1);
        foreach (dir_rows[k]) send_byte(dir_rows[k].data, dir_rows[k].kind, dir_rows[k].st);

        run_random(PHASE_ITEMS);
        settle_and_write(1'b0);
        run_random(PHASE_ITEMS);
        settle_and_write(1'b1);
        run_random(PHASE_ITEMS);

        if (burst_left != 0) begin
            i_valid    <= 1'b0;
            burst_left = 0;
        end
        while (exp_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && exp_frames.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/tpmc_pkg.sv
design/tpmc_crc.sv
design/top_packet_to_motor_commands.sv
dv/top_packet_to_motor_commands_tb.sv
